FILE: rtl/dq_pkg.sv
package dq_pkg;

    localparam int CAPACITY   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int COUNT_W    = 6;
    localparam int CMP_W      = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

    // Request codes.
    localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [2:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [2:0] REQ_POP_BACK   = 3'd3;
    localparam logic [2:0] REQ_REMOVE     = 3'd4;
    localparam logic [2:0] REQ_READ_FIRST = 3'd5;
    localparam logic [2:0] REQ_READ_LAST  = 3'd6;

    // Status codes.
    localparam logic [1:0] STAT_OK         = 2'd0;
    localparam logic [1:0] STAT_FULL       = 2'd1;
    localparam logic [1:0] STAT_EMPTY      = 2'd2;
    localparam logic [1:0] STAT_COUNT_ZERO = 2'd3;

    typedef struct packed {
        logic [2:0]         req_type;
        logic signed [31:0] key;
        logic [COUNT_W-1:0] count;
    } t_req;

    typedef struct packed {
        logic signed [31:0] value;
        logic [1:0]         status;
        logic               last_of_run;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_POP_WAIT,
        ST_RM_SCAN,
        ST_RD_SCAN
    } t_state;

    typedef struct packed {
        logic       load;
        logic       push;
        logic       pop;
        logic       pop_emit;
        logic       rm_init;
        logic       rm_step;
        logic       rm_finish;
        logic       rd_init;
        logic       rd_step;
        logic       emit_code_en;
        logic [1:0] emit_code;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req_type;
        logic       full;
        logic       empty;
        logic       cnt_zero;
        logic       rm_done;
        logic       rd_done;
    } t_stat;

    // Slot of the entry at a given position from the front, modulo the capacity.
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                  input logic [CNT_W-1:0] off);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
        if (s >= (CNT_W + 1)'(CAPACITY)) begin
            s = s - (CNT_W + 1)'(CAPACITY);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [VALUE_BITS-1:0] key_to_entry(input logic signed [31:0] key);
        logic signed [63:0] t;
        t = 64'(key);
        return t[VALUE_BITS-1:0];
    endfunction

    function automatic logic signed [31:0] entry_to_out(input logic [VALUE_BITS-1:0] e);
        logic signed [63:0] t;
        t = 64'(signed'(e));
        return t[31:0];
    endfunction

endpackage

FILE: rtl/dq_ctrl.sv
module dq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  dq_pkg::t_stat i_stat,
    output dq_pkg::t_cmd  o_cmd,
    output logic          o_busy
);

    dq_pkg::t_state r_state;
    dq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            dq_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = dq_pkg::ST_EXEC;
                end
            end
            dq_pkg::ST_EXEC: begin
                n_state = dq_pkg::ST_IDLE;
                unique case (i_stat.req_type) inside
                    dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK: begin
                        o_cmd.emit_code_en = 1'b1;
                        if (i_stat.full) begin
                            o_cmd.emit_code = dq_pkg::STAT_FULL;
                        end else begin
                            o_cmd.push      = 1'b1;
                            o_cmd.emit_code = dq_pkg::STAT_OK;
                        end
                    end
                    dq_pkg::REQ_POP_FRONT, dq_pkg::REQ_POP_BACK: begin
                        if (i_stat.empty) begin
                            o_cmd.emit_code_en = 1'b1;
                            o_cmd.emit_code    = dq_pkg::STAT_EMPTY;
                        end else begin
                            o_cmd.pop = 1'b1;
                            n_state   = dq_pkg::ST_POP_WAIT;
                        end
                    end
                    dq_pkg::REQ_REMOVE: begin
                        o_cmd.rm_init = 1'b1;
                        n_state       = dq_pkg::ST_RM_SCAN;
                    end
                    dq_pkg::REQ_READ_FIRST, dq_pkg::REQ_READ_LAST: begin
                        if (i_stat.empty) begin
                            o_cmd.emit_code_en = 1'b1;
                            o_cmd.emit_code    = dq_pkg::STAT_EMPTY;
                        end else if (i_stat.cnt_zero) begin
                            o_cmd.emit_code_en = 1'b1;
                            o_cmd.emit_code    = dq_pkg::STAT_COUNT_ZERO;
                        end else begin
                            o_cmd.rd_init = 1'b1;
                            n_state       = dq_pkg::ST_RD_SCAN;
                        end
                    end
                    default: begin
                        // Unused request code: no result and no change.
                    end
                endcase
            end
            dq_pkg::ST_POP_WAIT: begin
                o_cmd.pop_emit = 1'b1;
                n_state        = dq_pkg::ST_IDLE;
            end
            dq_pkg::ST_RM_SCAN: begin
                if (i_stat.rm_done) begin
                    o_cmd.rm_finish = 1'b1;
                    n_state         = dq_pkg::ST_IDLE;
                end else begin
                    o_cmd.rm_step = 1'b1;
                end
            end
            dq_pkg::ST_RD_SCAN: begin
                if (i_stat.rd_done) begin
                    n_state = dq_pkg::ST_IDLE;
                end else begin
                    o_cmd.rd_step = 1'b1;
                end
            end
            default: begin
                n_state = dq_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != dq_pkg::ST_IDLE);

endmodule

FILE: rtl/dq_dp.sv
module dq_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  dq_pkg::t_req  i_req,
    input  dq_pkg::t_cmd  i_cmd,
    output dq_pkg::t_stat o_stat,
    output logic          o_strobe,
    output dq_pkg::t_res  o_res
);

    logic [dq_pkg::VALUE_BITS-1:0] r_mem [dq_pkg::CAPACITY];
    logic [dq_pkg::VALUE_BITS-1:0] r_rdata;

    dq_pkg::t_req               r_req,   n_req;
    logic [dq_pkg::IDX_W-1:0]   r_front, n_front;
    logic [dq_pkg::CNT_W-1:0]   r_occ,   n_occ;
    logic [dq_pkg::CNT_W-1:0]   r_pos,   n_pos;
    logic [dq_pkg::CNT_W-1:0]   r_wcnt,  n_wcnt;
    logic [dq_pkg::CNT_W-1:0]   r_left,  n_left;
    logic                       r_pend,  n_pend;
    logic                       r_strobe, n_strobe;
    dq_pkg::t_res               r_res,   n_res;

    logic                          rd_en;
    logic [dq_pkg::IDX_W-1:0]      rd_addr;
    logic                          we;
    logic [dq_pkg::IDX_W-1:0]      wr_addr;
    logic [dq_pkg::VALUE_BITS-1:0] wr_data;

    logic [dq_pkg::VALUE_BITS-1:0] key_ent;
    logic [dq_pkg::IDX_W-1:0]      front_dec;
    logic [dq_pkg::IDX_W-1:0]      front_inc;
    logic [dq_pkg::CMP_W-1:0]      cnt_ext;
    logic [dq_pkg::CMP_W-1:0]      occ_ext;
    logic [dq_pkg::CNT_W-1:0]      rd_num;

    assign key_ent   = dq_pkg::key_to_entry(r_req.key);
    assign front_dec = (r_front == '0) ? dq_pkg::IDX_W'(dq_pkg::CAPACITY - 1)
                                       : r_front - 1'b1;
    assign front_inc = (r_front == dq_pkg::IDX_W'(dq_pkg::CAPACITY - 1)) ? '0
                                       : r_front + 1'b1;
    assign cnt_ext   = dq_pkg::CMP_W'(r_req.count);
    assign occ_ext   = dq_pkg::CMP_W'(r_occ);
    assign rd_num    = (cnt_ext < occ_ext) ? dq_pkg::CNT_W'(cnt_ext) : r_occ;

    always_comb begin
        n_req    = r_req;
        n_front  = r_front;
        n_occ    = r_occ;
        n_pos    = r_pos;
        n_wcnt   = r_wcnt;
        n_left   = r_left;
        n_pend   = r_pend;
        n_strobe = 1'b0;
        n_res    = r_res;
        rd_en    = 1'b0;
        rd_addr  = dq_pkg::slot_of(r_front, r_pos);
        we       = 1'b0;
        wr_addr  = dq_pkg::slot_of(r_front, r_occ);
        wr_data  = key_ent;

        if (i_cmd.load) begin
            n_req = i_req;
        end

        if (i_cmd.push) begin
            we    = 1'b1;
            n_occ = r_occ + 1'b1;
            if (r_req.req_type == dq_pkg::REQ_PUSH_FRONT) begin
                n_front = front_dec;
                wr_addr = front_dec;
            end
        end

        if (i_cmd.pop) begin
            rd_en = 1'b1;
            n_occ = r_occ - 1'b1;
            if (r_req.req_type == dq_pkg::REQ_POP_FRONT) begin
                rd_addr = r_front;
                n_front = front_inc;
            end else begin
                rd_addr = dq_pkg::slot_of(r_front, r_occ - 1'b1);
            end
            // The last entry leaving puts the front back at slot zero.
            if (r_occ == dq_pkg::CNT_W'(1)) begin
                n_front = '0;
            end
        end

        if (i_cmd.pop_emit) begin
            n_strobe          = 1'b1;
            n_res.value       = dq_pkg::entry_to_out(r_rdata);
            n_res.status      = dq_pkg::STAT_OK;
            n_res.last_of_run = 1'b1;
        end

        if (i_cmd.rm_init) begin
            n_pos  = '0;
            n_wcnt = '0;
            n_pend = 1'b0;
        end

        // Compaction: reads run one entry ahead of the compare, and kept
        // entries are written back at the write count, which trails the read.
        if (i_cmd.rm_step) begin
            if (r_pos < r_occ) begin
                rd_en  = 1'b1;
                n_pos  = r_pos + 1'b1;
                n_pend = 1'b1;
            end else begin
                n_pend = 1'b0;
            end
            if (r_pend && (r_rdata != key_ent)) begin
                we      = 1'b1;
                wr_addr = dq_pkg::slot_of(r_front, r_wcnt);
                wr_data = r_rdata;
                n_wcnt  = r_wcnt + 1'b1;
            end
        end

        if (i_cmd.rm_finish) begin
            n_occ = r_wcnt;
            if (r_wcnt == '0) begin
                n_front = '0;
            end
            n_strobe          = 1'b1;
            n_res.value       = 32'(r_occ - r_wcnt);
            n_res.status      = dq_pkg::STAT_OK;
            n_res.last_of_run = 1'b1;
        end

        if (i_cmd.rd_init) begin
            n_left = rd_num;
            n_pend = 1'b0;
            if (r_req.req_type == dq_pkg::REQ_READ_FIRST) begin
                n_pos = '0;
            end else begin
                n_pos = r_occ - rd_num;
            end
        end

        if (i_cmd.rd_step) begin
            if (r_left != '0) begin
                rd_en  = 1'b1;
                n_pos  = r_pos + 1'b1;
                n_left = r_left - 1'b1;
                n_pend = 1'b1;
            end else begin
                n_pend = 1'b0;
            end
            if (r_pend) begin
                n_strobe          = 1'b1;
                n_res.value       = dq_pkg::entry_to_out(r_rdata);
                n_res.status      = dq_pkg::STAT_OK;
                n_res.last_of_run = (r_left == '0);
            end
        end

        if (i_cmd.emit_code_en) begin
            n_strobe          = 1'b1;
            n_res.value       = '0;
            n_res.status      = i_cmd.emit_code;
            n_res.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front  <= '0;
            r_occ    <= '0;
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_front  <= n_front;
            r_occ    <= n_occ;
            r_pend   <= n_pend;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req  <= n_req;
        r_pos  <= n_pos;
        r_wcnt <= n_wcnt;
        r_left <= n_left;
        r_res  <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    assign o_stat.req_type = r_req.req_type;
    assign o_stat.full     = (r_occ == dq_pkg::CNT_W'(dq_pkg::CAPACITY));
    assign o_stat.empty    = (r_occ == '0);
    assign o_stat.cnt_zero = (r_req.count == '0);
    assign o_stat.rm_done  = (r_pos == r_occ) && !r_pend;
    assign o_stat.rd_done  = (r_left == '0) && !r_pend;

    assign o_strobe = r_strobe;
    assign o_res    = r_res;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= dq_pkg::CNT_W'(dq_pkg::CAPACITY))
        else $error("occupancy above capacity");

    a_empty_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_occ == '0) |-> (r_front == '0))
        else $error("empty store with front away from slot zero");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (we && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write of the same slot in one cycle");

    a_pend_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pend) |-> $past(rd_en))
        else $error("pending data without a preceding read");

endmodule

FILE: rtl/deque_with_value_removal_top.sv
// Bounded double-ended queue of signed values with removal by value.
// A request is presented on i_req and transferred at a rising edge where
// start is high and busy is low. busy stays high until every result of that
// request has been launched. Each result is presented on o_res with o_strobe
// high for exactly one cycle; the receiver cannot stall, so it must take each
// transfer as it comes. o_res.last_of_run marks the final result of a request.
// Remove value compacts the store entry by entry through the single memory
// read and write port. Read first or last n moves one entry per cycle through
// the memory read port, n being the number of entries read.
// Request code 7 produces no result.
// Reset is synchronous: the store is left empty with its front at slot zero.
// Stored entries themselves are not cleared, so no clearing pass is needed.
module deque_with_value_removal_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  dq_pkg::t_req i_req,
    output logic         o_strobe,
    output dq_pkg::t_res o_res
);

    dq_pkg::t_cmd  cmd;
    dq_pkg::t_stat stat;

    dq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    dq_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

endmodule
